### hdl/sha1_pkg.sv
package sha1_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       write_byte;
        logic [7:0] wr_data;
        logic       count_inc;
        logic       pad_fill;
        logic       zero_fill;
        logic       len_fill;
        logic       load;
        logic       round;
        logic       add;
        logic       reinit;
        logic [2:0] emit_index;
    } t_cmd;

    typedef struct packed {
        logic       round_last;
        logic [5:0] pos;
    } t_status;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [2:0]  LAST_INDEX = 3'd4;

endpackage

### hdl/sha1_datapath.sv
module sha1_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sha1_pkg::t_cmd   i_cmd,
    output sha1_pkg::t_status o_status,
    output logic [31:0]      o_word
);
    import sha1_pkg::*;

    logic [31:0] r_w   [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_h [5];
    logic [63:0] r_count, n_count;
    logic [6:0]  r_rnd;
    logic [63:0] w_bits;
    logic [4:0]  w_lane;
    logic [31:0] w_new, w_cur, w_f, w_k, w_tmp;

    assign w_bits = {r_count[60:0], 3'b000};
    assign w_lane = {~r_count[1:0], 3'b000};
    assign n_count = r_count + 64'd1;
    assign o_status.pos = r_count[5:0];
    assign o_status.round_last = (r_rnd == 7'd79);
    assign o_word = r_h[i_cmd.emit_index];

    assign w_new = {r_w[13][30:0] ^ r_w[8][30:0] ^ r_w[2][30:0] ^ r_w[0][30:0],
                    r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31]};
    assign w_cur = (r_rnd < 7'd16) ? r_w[0] : w_new;

    always_comb begin
        if (r_rnd < 7'd20) begin
            w_f = r_d ^ (r_b & (r_c ^ r_d));
            w_k = K0;
        end else if (r_rnd < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K1;
        end else if (r_rnd < 7'd60) begin
            w_f = (r_b & r_c) | (r_d & (r_b | r_c));
            w_k = K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K3;
        end
    end

    assign w_tmp = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + w_cur;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_byte) begin
            r_w[r_count[5:2]][w_lane +: 8] <= i_cmd.wr_data;
        end
        if (i_cmd.pad_fill) begin
            for (int i = 0; i < 64; i++) begin
                if (!i_cmd.len_fill || i < 56) begin
                    if (6'(i) == r_count[5:0]) begin
                        r_w[i >> 2][31 - 8 * (i & 3) -: 8] <= PAD_BYTE;
                    end else if (6'(i) > r_count[5:0]) begin
                        r_w[i >> 2][31 - 8 * (i & 3) -: 8] <= 8'h00;
                    end
                end
            end
        end
        if (i_cmd.zero_fill) begin
            for (int i = 0; i < 14; i++) begin
                r_w[i] <= '0;
            end
        end
        if (i_cmd.len_fill) begin
            r_w[14] <= w_bits[63:32];
            r_w[15] <= w_bits[31:0];
        end
        if (i_cmd.load) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end
        if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_cur;
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= w_tmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) begin
            r_h[0] <= H0;
            r_h[1] <= H1;
            r_h[2] <= H2;
            r_h[3] <= H3;
            r_h[4] <= H4;
            r_count <= '0;
            r_rnd <= '0;
        end else begin
            if (i_cmd.count_inc) begin
                r_count <= n_count;
            end
            if (i_cmd.load) begin
                r_rnd <= '0;
            end else if (i_cmd.round) begin
                r_rnd <= r_rnd + 7'd1;
            end
            if (i_cmd.add) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.round |-> r_rnd < 7'd80)
        else $error("round index out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> r_rnd == 7'd0)
        else $error("round index not cleared on load");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.count_inc && !i_cmd.reinit |=> r_count == $past(r_count) + 64'd1)
        else $error("byte count step");

endmodule

### hdl/sha1_control.sv
module sha1_control (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1_pkg::t_in_item i_in,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sha1_pkg::t_status  i_status,
    output sha1_pkg::t_cmd     o_cmd,
    output logic               o_out_valid,
    input  logic               i_out_stall
);
    import sha1_pkg::*;

    t_state     r_state, n_state;
    logic       r_end, n_end;
    logic       r_final, n_final;
    logic [2:0] r_idx, n_idx;
    logic       w_take;

    assign w_take = (r_state == ST_IDLE) && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_end = r_end;
        n_final = r_final;
        n_idx = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_end = i_in.end_of_message;
                    n_final = 1'b0;
                    if (i_in.byte_valid && i_status.pos == 6'd63) begin
                        n_state = ST_LOAD;
                    end else if (i_in.end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_LOAD:  n_state = ST_ROUND;
            ST_ROUND: if (i_status.round_last) n_state = ST_ADD;
            ST_ADD: begin
                if (r_final && r_end) begin
                    n_state = ST_LEN;
                end else if (r_final) begin
                    n_state = ST_EMIT;
                    n_idx = '0;
                end else if (r_end) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                n_state = ST_LOAD;
                n_final = 1'b1;
                n_end = (i_status.pos >= 6'd56);
            end
            ST_LEN: begin
                n_state = ST_LOAD;
                n_end = 1'b0;
                n_final = 1'b1;
            end
            ST_EMIT: begin
                if (!i_out_stall) begin
                    if (r_idx == LAST_INDEX) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.wr_data = i_in.data_byte;
        o_cmd.emit_index = r_idx;
        o_in_stall = (r_state != ST_IDLE);
        o_out_valid = (r_state == ST_EMIT);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.write_byte = w_take && i_in.byte_valid;
                o_cmd.count_inc = w_take && i_in.byte_valid;
            end
            ST_LOAD:  o_cmd.load = 1'b1;
            ST_ROUND: o_cmd.round = 1'b1;
            ST_ADD:   o_cmd.add = 1'b1;
            ST_PAD: begin
                o_cmd.pad_fill = 1'b1;
                o_cmd.len_fill = (i_status.pos < 6'd56);
            end
            ST_LEN: begin
                o_cmd.len_fill = 1'b1;
                o_cmd.zero_fill = 1'b1;
            end
            ST_EMIT:  o_cmd.reinit = !i_out_stall && (r_idx == LAST_INDEX);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_end <= 1'b0;
            r_final <= 1'b0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_end <= n_end;
            r_final <= n_final;
            r_idx <= n_idx;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_idx <= LAST_INDEX)
        else $error("emit index out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(r_idx))
        else $error("stalled transfer moved");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ADD && r_final && !r_end |=> r_state == ST_EMIT)
        else $error("final block did not lead to emit");

endmodule

### hdl/sha1_message_hash.sv
// Channel | Handshake                 | Payload
// in      | i_in_valid / o_in_stall   | i_in  (data_byte, byte_valid, end_of_message)
// out     | o_out_valid / i_out_stall | o_out (digest_word, word_index, last_word)
// One byte a cycle while not stalled; a block's 64th byte starts load, 80 rounds and add.
// End of message: padding, a length step if needed, one or two compressions, then 5 words.
// The single round unit, one round a cycle, sets the block time.
// Reset is synchronous active low and reloads the chaining words and byte count.
// Input stalls while a block compresses or digest words are out; output stall holds a word.
module sha1_message_hash (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sha1_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sha1_pkg::t_out_item  o_out
);
    import sha1_pkg::*;

    t_cmd        w_cmd;
    t_status     w_status;
    logic [31:0] w_word;

    sha1_control u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall)
    );

    sha1_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_status(w_status),
        .o_word  (w_word)
    );

    assign o_out.digest_word = w_word;
    assign o_out.word_index = w_cmd.emit_index;
    assign o_out.last_word = (w_cmd.emit_index == LAST_INDEX);

endmodule
